// File: rtl/clnwq_pkg.sv
package clnwq_pkg;

   localparam int NIB_W   = 4;
   localparam int BYTE_W  = 8;
   localparam int STATUS_W = 2;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic             cmd;
      logic [NIB_W-1:0] nibble;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                strobe_res;
      logic [NIB_W-1:0]    bus_nibble;
      logic                register_select;
   } rsp_type;

endpackage

// File: rtl/char_lcd_nibble_write_queue_core.sv
// Write queue for a character LCD on a 4-bit bus.
// Input channel (req_valid/req_stall): req_type 0 pushes req_byte_value as
// two nibbles, high first, each tagged with req_is_command; req_type 1 is a
// tick that pops one nibble for the display.
// Result channel (rsp_valid/rsp_stall): one word per accepted item. rsp_status
// is done, full (push refused, fewer than two free slots) or empty (tick with
// nothing queued). A popped nibble comes with rsp_strobe_res high,
// rsp_bus_nibble (bit 3 is D7) and rsp_register_select (0 command, 1 data).
// Items are handled one at a time around a single-port nibble store.
// A push writes the high nibble on acceptance and the low one in ST_PUSH2; a
// tick with data forms its result in ST_READ from the registered store read;
// a refused push or empty tick forms it at once for the output register.
// The output register holds one word; while the receiver stalls, one more
// item is accepted and its result is parked until the output drains.
// Reset empties the queue and the output register; store contents are left
// as they are and are never read before being written.
module char_lcd_nibble_write_queue_core #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_type,
   input  logic [7:0] req_byte_value,
   input  logic       req_is_command,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic       rsp_strobe_res,
   output logic [3:0] rsp_bus_nibble,
   output logic       rsp_register_select
);
   import clnwq_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PUSH2 = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_HOLD  = 2'd3;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   logic [1:0]       state_ff, state_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   entry_type        low_ff, low_in;
   rsp_type          pend_ff, pend_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             ram_we;
   logic [PTR_W-1:0] ram_addr;
   entry_type        ram_wentry;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type        rd_entry;

   logic             req_accept;
   logic             out_free;
   logic             has_room;
   logic             finish;
   rsp_type          res;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign has_room   = (cnt_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign rd_entry   = entry_type'(ram_rdata);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      cnt_in       = cnt_ff;
      low_in       = low_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we       = 1'b0;
      ram_addr     = wp_ff;
      ram_wentry   = low_ff;
      finish       = 1'b0;
      res          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_type == REQ_PUSH) begin
                  if (has_room) begin
                     ram_we     = 1'b1;
                     ram_addr   = wp_ff;
                     ram_wentry = '{cmd: req_is_command, nibble: req_byte_value[7:4]};
                     low_in     = '{cmd: req_is_command, nibble: req_byte_value[3:0]};
                     wp_in      = ptr_next(wp_ff);
                     cnt_in     = cnt_ff + CNT_W'(2);
                     state_in   = ST_PUSH2;
                  end else begin
                     res.status = STATUS_FULL;
                     finish     = 1'b1;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     res.status = STATUS_EMPTY;
                     finish     = 1'b1;
                  end else begin
                     ram_addr = rp_ff;
                     rp_in    = ptr_next(rp_ff);
                     cnt_in   = cnt_ff - CNT_W'(1);
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_PUSH2: begin
            ram_we     = 1'b1;
            ram_addr   = wp_ff;
            ram_wentry = low_ff;
            wp_in      = ptr_next(wp_ff);
            res.status = STATUS_DONE;
            finish     = 1'b1;
         end
         ST_READ: begin
            res.status          = STATUS_DONE;
            res.strobe_res      = 1'b1;
            res.bus_nibble      = rd_entry.nibble;
            res.register_select = !rd_entry.cmd;
            finish              = 1'b1;
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         if (out_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            pend_in  = res;
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      low_ff  <= low_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   clnwq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wentry),
      .rdata (ram_rdata)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_strobe_res      = rsp_ff.strobe_res;
   assign rsp_bus_nibble      = rsp_ff.bus_nibble;
   assign rsp_register_select = rsp_ff.register_select;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("fill count above queue depth");

   a_push_second: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_type == REQ_PUSH && has_room) |=> state_ff == ST_PUSH2)
      else $error("push did not move to second write");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HOLD |-> rsp_valid_ff && $past(rsp_stall))
      else $error("parked result without a stalled output word");

   a_tick_strobe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_strobe_res) |-> rsp_status == STATUS_DONE)
      else $error("strobe with non-done status");
`endif

endmodule

// File: rtl/clnwq_ram.sv
module clnwq_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
